// File: hw/rtl/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;
    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds = 64;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic load_byte;
        logic load_pad;
        logic load_len;
        logic zero_fill;
        logic start;
        logic restart;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic block_full;
        logic [5:0] fill;
    } t_status;

    function automatic t_word round_k(input logic [5:0] i);
        t_word k;
        case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word init_hash(input logic [2:0] i);
        t_word h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction
endpackage

// File: hw/rtl/sha_if.sv
`timescale 1ns / 1ps
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
    modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
    modport sink (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: hw/rtl/sha_datapath.sv
`timescale 1ns / 1ps
module sha_datapath
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_byte,
    input  logic [2:0] i_word_sel,
    output t_status    o_status,
    output t_word      o_word
);
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    t_word       r_h [8];
    t_word       r_v [8];
    t_word       r_w [16];
    logic [5:0]  r_round;
    logic        r_busy;
    logic        r_full;

    t_word s0, s1, wn, t1, t2, e, a, wcur;
    logic       wr_en;
    logic [7:0] wr_byte;

    always_comb begin
        e = r_v[4];
        a = r_v[0];
        wcur = r_w[0];
        s0 = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]} ^ (r_w[1] >> 3);
        s1 = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
            ^ (r_w[14] >> 10);
        wn = s1 + r_w[9] + s0 + r_w[0];
        t1 = r_v[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
            + ((e & r_v[5]) ^ (~e & r_v[6])) + round_k(r_round) + wcur;
        t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
            + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
        wr_en = i_cmd.load_byte || i_cmd.load_pad || i_cmd.zero_fill || i_cmd.load_len;
        if (i_cmd.load_byte) wr_byte = i_byte;
        else if (i_cmd.load_pad) wr_byte = 8'h80;
        else if (i_cmd.load_len) wr_byte = r_bits[{~r_fill[2:0], 3'b000} +: 8];
        else wr_byte = 8'h00;
    end

    // block bytes shift into the schedule words, first byte ends up in the top of r_w[0]
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_bits  <= '0;
            r_busy  <= 1'b0;
            r_full  <= 1'b0;
            r_round <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= init_hash(3'(i));
        end else begin
            r_full <= wr_en && (r_fill == 6'd63);
            if (i_cmd.restart) begin
                r_fill <= '0;
                r_bits <= '0;
                for (int i = 0; i < 8; i++) r_h[i] <= init_hash(3'(i));
            end else if (wr_en) begin
                for (int i = 0; i < 15; i++) r_w[i] <= {r_w[i][23:0], r_w[i + 1][31:24]};
                r_w[15] <= {r_w[15][23:0], wr_byte};
                r_fill <= r_fill + 6'd1;
                if (i_cmd.load_byte) r_bits <= r_bits + 64'd8;
            end else if (i_cmd.start) begin
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                r_round <= '0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                r_w[15] <= wn;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_round <= r_round + 6'd1;
                if (r_round == 6'(Rounds - 1)) begin
                    r_busy <= 1'b0;
                    r_h[0] <= r_h[0] + t1 + t2;
                    r_h[1] <= r_h[1] + r_v[0];
                    r_h[2] <= r_h[2] + r_v[1];
                    r_h[3] <= r_h[3] + r_v[2];
                    r_h[4] <= r_h[4] + r_v[3] + t1;
                    r_h[5] <= r_h[5] + r_v[4];
                    r_h[6] <= r_h[6] + r_v[5];
                    r_h[7] <= r_h[7] + r_v[6];
                end
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.block_full = r_full;
    assign o_status.fill = r_fill;
    assign o_word = r_h[i_word_sel];
endmodule

// File: hw/rtl/sha_ctrl.sv
`timescale 1ns / 1ps
module sha_ctrl
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    sha_in_if.sink     in_ch,
    sha_out_if.source  out_ch,
    input  t_status    i_status,
    input  t_word      i_word,
    output t_cmd       o_cmd,
    output logic [2:0] o_word_sel
);
    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_PAD, S_FILL, S_WAIT, S_OUT
    } t_state;

    t_state     r_state;
    logic       r_last;
    logic       r_final;
    logic       r_padded;
    logic [2:0] r_idx;
    logic       r_ovalid;
    t_word      r_oword;
    logic       acc;
    logic       out_acc;

    assign in_ch.ready = (r_state == S_IDLE);
    assign acc = in_ch.valid && in_ch.ready;
    assign out_acc = r_ovalid && out_ch.ready;
    assign o_word_sel = r_ovalid ? r_idx + 3'd1 : r_idx;

    always_comb begin
        o_cmd = '0;
        o_cmd.load_byte = acc && in_ch.byte_valid;
        case (r_state)
            S_CHECK: o_cmd.start = i_status.block_full;
            S_PAD:   o_cmd.load_pad = 1'b1;
            S_FILL: begin
                if (i_status.block_full) o_cmd.start = 1'b1;
                else if (r_final || i_status.fill == 6'd56) o_cmd.load_len = 1'b1;
                else o_cmd.zero_fill = 1'b1;
            end
            S_OUT:   o_cmd.restart = out_acc && r_idx == 3'd7;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_last   <= 1'b0;
            r_final  <= 1'b0;
            r_padded <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (acc) begin
                    r_last <= in_ch.end_of_message;
                    if (in_ch.byte_valid || in_ch.end_of_message) r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (i_status.block_full) r_state <= S_WAIT;
                    else if (r_last) r_state <= S_PAD;
                    else r_state <= S_IDLE;
                end
                S_PAD: begin
                    r_padded <= 1'b1;
                    r_state  <= S_FILL;
                end
                S_FILL: begin
                    if (i_status.block_full) r_state <= S_WAIT;
                    else if (i_status.fill == 6'd56) r_final <= 1'b1;
                end
                S_WAIT: if (!i_status.busy) begin
                    if (r_final) r_state <= S_OUT;
                    else if (!r_last) r_state <= S_IDLE;
                    else if (r_padded) r_state <= S_FILL;
                    else r_state <= S_PAD;
                end
                S_OUT: begin
                    if (out_acc && r_idx == 3'd7) begin
                        r_ovalid <= 1'b0;
                        r_idx    <= '0;
                        r_last   <= 1'b0;
                        r_final  <= 1'b0;
                        r_padded <= 1'b0;
                        r_state  <= S_IDLE;
                    end else if (!r_ovalid || out_ch.ready) begin
                        r_ovalid <= 1'b1;
                        r_oword  <= i_word;
                        if (r_ovalid) r_idx <= r_idx + 3'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid = r_ovalid;
    assign out_ch.digest_word = r_oword;
    assign out_ch.word_index = r_idx;
    assign out_ch.last_word = (r_idx == 3'd7);
endmodule

// File: hw/rtl/sha256_stream_hasher_top.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload
// in_ch    in   data_byte[7:0], byte_valid, end_of_message
// out_ch   out  digest_word[31:0], word_index[2:0], last_word
// A byte transfer passes through a check state before the next byte is taken; each full block then
// holds input for the compression loop, which runs one round per cycle.
// End of message adds padding writes, one or two compressions and eight output transfers.
// Reset is synchronous, active low. Output stalls hold the digest word in its register.
module sha256_stream_hasher_top
    import sha_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    t_cmd       cmd;
    t_status    status;
    t_word      word;
    logic [2:0] word_sel;

    sha_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .i_status(status), .i_word(word), .o_cmd(cmd), .o_word_sel(word_sel)
    );

    sha_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_byte(in_ch.data_byte),
        .i_word_sel(word_sel), .o_status(status), .o_word(word)
    );
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import sha_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_msg_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_out;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_stream_hasher_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    t_msg_item   pending_items [$];
    t_digest_out expected_words [$];
    logic [31:0] mdl_hash [8];
    logic [7:0]  mdl_buf [64];
    logic [63:0] mdl_bits;
    logic [5:0]  mdl_fill;
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned hold_off;
    bit          hold_for_drain;
    bit          long_stall_req;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
            w[i] = {mdl_buf[4*i], mdl_buf[4*i+1], mdl_buf[4*i+2], mdl_buf[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
                   (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        v = mdl_hash;
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
                 ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
                 ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            mdl_hash[i] += v[i];
    endtask

    task automatic restart_hash();
        mdl_hash = H_INIT;
        mdl_bits = '0;
        mdl_fill = '0;
    endtask

    task automatic hash_transfer(input t_msg_item it);
        if (it.byte_valid) begin
            mdl_buf[mdl_fill] = it.data_byte;
            mdl_bits += 64'd8;
            mdl_fill++;
            if (mdl_fill == 0)
                compress_block();
        end
        if (it.end_of_message) begin
            mdl_buf[mdl_fill] = 8'h80;
            mdl_fill++;
            if (mdl_fill == 0 || mdl_fill > 56) begin
                for (int i = mdl_fill; i < 64 && mdl_fill != 0; i++)
                    mdl_buf[i] = 8'h00;
                compress_block();
                mdl_fill = '0;
            end
            for (int i = mdl_fill; i < 56; i++)
                mdl_buf[i] = 8'h00;
            for (int i = 0; i < 8; i++)
                mdl_buf[63-i] = mdl_bits[8*i +: 8];
            compress_block();
            for (int i = 0; i < 8; i++)
                expected_words.push_back('{mdl_hash[i], 3'(i), i == 7});
            restart_hash();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic add_byte(input logic [7:0] b, input bit eom);
        pending_items.push_back('{b, 1'b1, eom});
    endtask

    task automatic add_message(input int unsigned len);
        for (int i = 0; i < len; i++)
            add_byte(8'($urandom), i == len - 1);
        if (len == 0)
            pending_items.push_back('{8'($urandom), 1'b0, 1'b1});
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                hash_transfer(pending_items.pop_front());
            end
            if (in_ch.valid && !in_ch.ready) begin
            end else if (hold_for_drain && pending_items.size() == 0) begin
                in_ch.valid <= 1'b0;
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
                in_ch.valid <= 1'b1;
                {in_ch.data_byte, in_ch.byte_valid, in_ch.end_of_message} <=
                    pending_items[0];
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        t_digest_out got;
        t_digest_out want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_off <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.digest_word, out_ch.word_index, out_ch.last_word};
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", got.digest_word, '0);
                end else begin
                    want = expected_words.pop_front();
                    if (got.digest_word !== want.digest_word)
                        report_mismatch("digest_word", got.digest_word, want.digest_word);
                    if (got.word_index !== want.word_index)
                        report_mismatch("word_index", 32'(got.word_index),
                                        32'(want.word_index));
                    if (got.last_word !== want.last_word)
                        report_mismatch("last_word", 32'(got.last_word),
                                        32'(want.last_word));
                end
            end
            if (long_stall_req && hold_off == 0) begin
                hold_off <= 3000;
                out_ch.ready <= 1'b0;
            end else if (hold_off != 0) begin
                hold_off <= hold_off - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= (cycle_count % 512 < 200) ? 1'b1 :
                                ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("sha256_stream_hasher_top regression: fail");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        int unsigned sent;
        error_count = 0;
        cycle_count = 0;
        hold_for_drain = 0;
        long_stall_req = 0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.byte_valid = 1'b0;
        in_ch.end_of_message = 1'b0;
        out_ch.ready = 1'b0;
        restart_hash();
        foreach (mdl_buf[i]) mdl_buf[i] = '0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty, idles, extremes, "abc", end of message sent without a byte
        pending_items.push_back('{8'hff, 1'b0, 1'b1});
        pending_items.push_back('{8'h00, 1'b0, 1'b0});
        add_byte(8'h00, 1'b0);
        pending_items.push_back('{8'hff, 1'b0, 1'b0});
        add_byte(8'hff, 1'b1);
        add_byte(8'h61, 1'b0); add_byte(8'h62, 1'b0);
        pending_items.push_back('{8'h63, 1'b1, 1'b1});
        add_byte(8'h5a, 1'b0);
        pending_items.push_back('{8'ha5, 1'b0, 1'b1});

        // pause until every digest has come back
        hold_for_drain = 1;
        wait (pending_items.size() == 0 && expected_words.size() == 0);
        repeat (20) @(posedge i_clk);
        hold_for_drain = 0;

        add_message(55); add_message(56); add_message(63); add_message(64);

        // long receiver stall while further messages are still offered
        long_stall_req = 1;
        wait (hold_off != 0);
        long_stall_req = 0;
        add_message(3); add_message(5); add_message(0); add_message(2);

        sent = 0;
        while (sent < 220) begin
            wait (pending_items.size() < 64);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 130) : $urandom_range(0, 20);
            add_message(n);
            sent += (n == 0) ? 1 : n;
            if ($urandom_range(0, 4) == 0)
                pending_items.push_back('{8'($urandom), 1'b0, 1'b0});
        end
        wait (pending_items.size() == 0 && expected_words.size() == 0);
        repeat (200) @(posedge i_clk);
        if (error_count == 0)
            $display("sha256_stream_hasher_top regression: pass");
        else
            $display("sha256_stream_hasher_top regression: fail");
        $finish;
    end
endmodule
